FILE: design/plti_pkg.sv
// ============================================================================
// plti_pkg
// Shared widths, codes and types of the piecewise-linear curve lookup block.
// ============================================================================
package plti_pkg;

    localparam int WL_W  = 24;   // wavelength, unsigned Q16.8
    localparam int VAL_W = 17;   // curve value, unsigned Q1.16
    localparam int CNT_W = 7;    // entry_count register
    localparam int IDX_W = 6;    // entry_index field
    localparam int NUM_W = 41;   // magnitude of (v1-v0)*(w-w0)
    localparam int DEN_W = 24;   // magnitude of (w1-w0)

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_ENTRY_COUNT = 1'b0;
    localparam logic CFG_FALLBACK    = 1'b1;

    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    typedef struct packed {
        logic [WL_W-1:0]  wl;
        logic [VAL_W-1:0] val;
    } t_entry;

    // Travels with a query: when direct is set, v0 is already the answer.
    typedef struct packed {
        logic             direct;
        logic             fb;
        logic [VAL_W-1:0] v0;
    } t_tag;

endpackage

FILE: design/plti_div.sv
// ============================================================================
// plti_div
// Pipelined signed divider, one quotient bit per stage, truncating to zero.
// ============================================================================
module plti_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic signed [plti_pkg::NUM_W:0]  i_num,
    input  logic signed [plti_pkg::DEN_W:0]  i_den,
    input  plti_pkg::t_tag                   i_tag,
    output logic                             o_valid,
    output logic signed [plti_pkg::NUM_W:0]  o_quot,
    output plti_pkg::t_tag                   o_tag
);
    import plti_pkg::*;

    // Stage 0 holds the operand magnitudes; stage k has produced k quotient bits.
    logic [NUM_W:0]   r_vld;
    logic [NUM_W-1:0] r_a   [NUM_W+1];
    logic [DEN_W-1:0] r_rem [NUM_W+1];
    logic [DEN_W-1:0] r_b   [NUM_W+1];
    logic             r_neg [NUM_W+1];
    t_tag             r_tag [NUM_W+1];

    logic [NUM_W-1:0] n_anum;
    logic [DEN_W-1:0] n_aden;

    assign n_anum = i_num[NUM_W] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign n_aden = i_den[DEN_W] ? DEN_W'(-i_den) : DEN_W'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a[0]   <= n_anum;
        r_rem[0] <= '0;
        r_b[0]   <= n_aden;
        r_neg[0] <= i_num[NUM_W] ^ i_den[DEN_W];
        r_tag[0] <= i_tag;
    end

    for (genvar k = 1; k <= NUM_W; k++) begin : g_step
        logic [DEN_W:0]   w_trial;
        logic             w_ge;
        logic [DEN_W-1:0] n_rem;

        assign w_trial = {r_rem[k-1], r_a[k-1][NUM_W-1]};
        assign w_ge    = w_trial >= {1'b0, r_b[k-1]};
        // The partial remainder stays below the divisor, so it fits DEN_W bits.
        assign n_rem   = w_ge ? DEN_W'(w_trial - {1'b0, r_b[k-1]}) : w_trial[DEN_W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_a[k]   <= {r_a[k-1][NUM_W-2:0], w_ge};
            r_rem[k] <= n_rem;
            r_b[k]   <= r_b[k-1];
            r_neg[k] <= r_neg[k-1];
            r_tag[k] <= r_tag[k-1];
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_tag   = r_tag[NUM_W];
    assign o_quot  = r_neg[NUM_W] ? -$signed({1'b0, r_a[NUM_W]}) : $signed({1'b0, r_a[NUM_W]});

endmodule

FILE: design/piecewise_linear_table_interp_top.sv
// ============================================================================
// piecewise_linear_table_interp_top
// Piecewise-linear curve lookup: table of (wavelength, value) points and a
// pipelined search and interpolation of query wavelengths.
// ============================================================================
// Usage:
// A request is taken at a clock edge with i_start high and o_busy low. A write
// request (i_op = write) stores i_wavelength and i_entry_value into slot
// i_entry_index and gives no result. A query request returns one result on
// o_value and o_used_fallback, marked by o_valid for exactly one cycle.
// Queries may be issued in every cycle. A result passes the end-point stage,
// the search stages (one per halving), the bracketing-pair and product stages,
// the 42-stage divider (an operand register plus one stage per quotient bit)
// and the output register.
// o_busy is high only for a write request while queries are still in the
// pipeline, so a write waits until every earlier query has been answered.
// The configuration port writes entry_count (index 0) and fallback_value
// (index 1) at any edge with i_cfg_we high; write it only while no query is in
// flight. Reset clears both registers and the pipeline; table slots hold
// nothing defined until written. The receiver cannot stall: a result is
// presented once and must be taken.
// ============================================================================
module piecewise_linear_table_interp_top #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_op,
    input  logic [plti_pkg::IDX_W-1:0]     i_entry_index,
    input  logic [plti_pkg::WL_W-1:0]      i_wavelength,
    input  logic [plti_pkg::VAL_W-1:0]     i_entry_value,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [plti_pkg::VAL_W-1:0]     i_cfg_data,
    output logic                           o_valid,
    output logic [plti_pkg::VAL_W-1:0]     o_value,
    output logic                           o_used_fallback
);
    import plti_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int NW    = $clog2(TABLE_DEPTH + 1);
    localparam int SS    = AW;
    localparam int NCOPY = SS + 2;
    localparam int CW    = $clog2(SS + NUM_W + 8);

    // ---------------- configuration ----------------
    logic [CNT_W-1:0] r_count;
    logic [VAL_W-1:0] r_fallback;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_fallback <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENTRY_COUNT: r_count    <= i_cfg_data[CNT_W-1:0];
                CFG_FALLBACK:    r_fallback <= i_cfg_data;
            endcase
        end
    end

    // ---------------- request acceptance ----------------
    logic           w_accept;
    logic           w_write;
    logic           w_query;
    logic [AW-1:0]  w_waddr;
    logic [NW-1:0]  w_ncl;
    logic [AW-1:0]  w_last;
    logic [CW-1:0]  r_inflight;
    logic [CW-1:0]  n_inflight;
    logic           r_out_vld;

    assign w_accept = i_start && !o_busy;
    assign w_write  = w_accept && (i_op == OP_WRITE) && (32'(i_entry_index) < TABLE_DEPTH);
    assign w_query  = w_accept && (i_op == OP_QUERY);
    assign w_waddr  = AW'(i_entry_index);
    assign w_ncl    = (32'(r_count) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(r_count);
    assign w_last   = AW'(w_ncl - 1'b1);

    assign n_inflight = r_inflight + CW'(w_query) - CW'(r_out_vld);
    assign o_busy     = (r_inflight != '0) && (i_op == OP_WRITE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    // One copy of the table per read site: each search stage, the end-point
    // check and the bracketing-pair fetch.
    t_entry r_mem [NCOPY][TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            for (int c = 0; c < NCOPY; c++) begin
                r_mem[c][w_waddr] <= '{wl: i_wavelength, val: i_entry_value};
            end
        end
    end

    // ---------------- stage A: end points ----------------
    logic             r_a_vld;
    logic [WL_W-1:0]  r_a_w;
    logic [NW-1:0]    r_a_n;
    t_entry           r_a_first;
    t_entry           r_a_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= w_query;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_w     <= i_wavelength;
        r_a_n     <= w_ncl;
        r_a_first <= r_mem[SS][0];
        r_a_last  <= r_mem[SS][w_last];
    end

    t_tag w_b_tag;
    logic w_b_empty;
    logic w_b_low;
    logic w_b_high;

    assign w_b_empty = (r_a_n == '0);
    assign w_b_low   = r_a_w <= r_a_first.wl;
    assign w_b_high  = r_a_w >= r_a_last.wl;

    always_comb begin
        w_b_tag.direct = w_b_empty || w_b_low || w_b_high;
        w_b_tag.fb     = w_b_empty;
        priority if (w_b_empty) begin
            w_b_tag.v0 = r_fallback;
        end else if (w_b_low) begin
            w_b_tag.v0 = r_a_first.val;
        end else begin
            w_b_tag.v0 = r_a_last.val;
        end
    end

    // ---------------- binary search stages ----------------
    logic [SS-1:0]   r_s_vld;
    logic [WL_W-1:0] r_s_w   [SS];
    logic [AW-1:0]   r_s_lo  [SS];
    logic [AW-1:0]   r_s_hi  [SS];
    logic [AW-1:0]   r_s_mid [SS];
    t_entry          r_s_rd  [SS];
    t_tag            r_s_tag [SS];
    logic [AW-1:0]   w_lo    [SS+1];
    logic [AW-1:0]   w_hi    [SS+1];

    assign w_lo[0] = '0;
    assign w_hi[0] = AW'(r_a_n - 1'b1);

    for (genvar k = 0; k < SS; k++) begin : g_search
        logic [AW:0]     w_sum;
        logic [AW-1:0]   w_mid;
        logic            w_in_vld;
        logic [WL_W-1:0] w_in_w;
        t_tag            w_in_tag;

        assign w_sum = {1'b0, w_lo[k]} + {1'b0, w_hi[k]};
        assign w_mid = w_sum[AW:1];

        if (k == 0) begin : g_first
            assign w_in_vld = r_a_vld;
            assign w_in_w   = r_a_w;
            assign w_in_tag = w_b_tag;
        end else begin : g_next
            assign w_in_vld = r_s_vld[k-1];
            assign w_in_w   = r_s_w[k-1];
            assign w_in_tag = r_s_tag[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_vld[k] <= 1'b0;
            end else begin
                r_s_vld[k] <= w_in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_s_w[k]   <= w_in_w;
            r_s_lo[k]  <= w_lo[k];
            r_s_hi[k]  <= w_hi[k];
            r_s_mid[k] <= w_mid;
            r_s_rd[k]  <= r_mem[k][w_mid];
            r_s_tag[k] <= w_in_tag;
        end

        // The search stops narrowing once the pair is adjacent.
        always_comb begin
            w_lo[k+1] = r_s_lo[k];
            w_hi[k+1] = r_s_hi[k];
            if (AW'(r_s_hi[k] - r_s_lo[k]) > AW'(1)) begin
                if (r_s_rd[k].wl < r_s_w[k]) begin
                    w_lo[k+1] = r_s_mid[k];
                end else begin
                    w_hi[k+1] = r_s_mid[k];
                end
            end
        end
    end

    // ---------------- stage F: bracketing pair ----------------
    logic            r_f_vld;
    logic [WL_W-1:0] r_f_w;
    t_tag            r_f_tag;
    t_entry          r_f_e0;
    t_entry          r_f_e1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_s_vld[SS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_w   <= r_s_w[SS-1];
        r_f_tag <= r_s_tag[SS-1];
        r_f_e0  <= r_mem[SS+1][w_lo[SS]];
        r_f_e1  <= r_mem[SS+1][w_hi[SS]];
    end

    // ---------------- stage G: product and divisor ----------------
    logic signed [VAL_W:0]       w_dv;
    logic signed [WL_W:0]        w_dx;
    logic signed [WL_W:0]        w_den;
    logic signed [VAL_W+WL_W:0]  w_prod;
    t_tag                        w_g_tag;
    logic                        r_g_vld;
    logic signed [NUM_W:0]       r_g_prod;
    logic signed [DEN_W:0]       r_g_den;
    t_tag                        r_g_tag;

    assign w_dv   = $signed({1'b0, r_f_e1.val}) - $signed({1'b0, r_f_e0.val});
    // For an interpolated query the query lies above the lower point, so this difference is positive.
    assign w_dx   = $signed({1'b0, r_f_w}) - $signed({1'b0, r_f_e0.wl});
    assign w_den  = $signed({1'b0, r_f_e1.wl}) - $signed({1'b0, r_f_e0.wl});
    assign w_prod = w_dv * w_dx;

    always_comb begin
        w_g_tag = r_f_tag;
        if (!r_f_tag.direct) begin
            w_g_tag.direct = (w_den == '0);
            w_g_tag.v0     = r_f_e0.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_prod <= w_prod[NUM_W:0];
        r_g_den  <= w_den;
        r_g_tag  <= w_g_tag;
    end

    // ---------------- division ----------------
    logic                  w_d_vld;
    logic signed [NUM_W:0] w_d_quot;
    t_tag                  w_d_tag;

    plti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_g_vld),
        .i_num   (r_g_prod),
        .i_den   (r_g_den),
        .i_tag   (r_g_tag),
        .o_valid (w_d_vld),
        .o_quot  (w_d_quot),
        .o_tag   (w_d_tag)
    );

    // ---------------- output stage ----------------
    logic signed [NUM_W+1:0] w_sum;
    logic [VAL_W-1:0]        n_value;
    logic [VAL_W-1:0]        r_out_value;
    logic                    r_out_fb;

    assign w_sum = $signed({{(NUM_W+2-VAL_W){1'b0}}, w_d_tag.v0}) + {w_d_quot[NUM_W], w_d_quot};

    always_comb begin
        priority if (w_d_tag.direct) begin
            n_value = w_d_tag.v0;
        end else if (w_sum[NUM_W+1]) begin
            n_value = '0;
        end else if (|w_sum[NUM_W:VAL_W]) begin
            n_value = VAL_MAX;
        end else begin
            n_value = w_sum[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_out_fb  <= 1'b0;
        end else begin
            r_out_vld <= w_d_vld;
            r_out_fb  <= w_d_vld && w_d_tag.fb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value <= n_value;
    end

    assign o_valid         = r_out_vld;
    assign o_value         = r_out_value;
    assign o_used_fallback = r_out_fb;

endmodule

FILE: design/plti_chk.sv
// ============================================================================
// plti_chk
// Port-level checks of the curve lookup block, bound to the top level.
// ============================================================================
module plti_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_op,
    input logic o_busy,
    input logic o_valid,
    input logic o_used_fallback
);
    import plti_pkg::*;

    // The cycle after reset shows no result.
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // Reset drains the pipeline, so no request is held off right after it.
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_busy)
        else $error("busy right after reset");

    // The fallback flag belongs to a result.
    a_fallback_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_used_fallback |-> o_valid)
        else $error("fallback flag without a result");

    // Only a write request is ever held off; queries stream freely.
    a_busy_only_for_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> (i_op == OP_WRITE))
        else $error("query request held off");

endmodule

bind piecewise_linear_table_interp_top plti_chk u_plti_chk (.*);
